### rtl/core/fir_pkg.sv
// Shared definitions for the streaming FIR filter: operation codes,
// sequencer states and the control bundle passed to the MAC datapath.
// No dependencies.
package fir_pkg;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam int TAP_COUNT_RESET = 51;
   localparam int ACC_GUARD_BITS  = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_FINISH
   } fir_state_type;

   typedef struct packed {
      logic clear;
      logic valid;
      logic use_sample;
      logic hist_ok;
   } mac_ctl_type;

endpackage

### rtl/core/fir_mac.sv
// Shared multiply-accumulate for the FIR filter: registered product,
// wide accumulator, round-half-up and saturation to the sample format.
// Depends on fir_pkg.
module fir_mac #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fir_pkg::mac_ctl_type          ctl,
   input  logic signed [SAMPLE_BITS-1:0] coef,
   input  logic signed [SAMPLE_BITS-1:0] hist,
   input  logic signed [SAMPLE_BITS-1:0] x0,
   output logic                          busy,
   output logic signed [SAMPLE_BITS-1:0] result,
   output logic                          result_sat
);

   localparam int PROD_BITS = 2 * SAMPLE_BITS;
   localparam int ACC_BITS  = PROD_BITS + fir_pkg::ACC_GUARD_BITS;
   localparam int RND_BITS  = ACC_BITS + 1;
   localparam logic [RND_BITS-1:0] HALF = RND_BITS'(1) << (SAMPLE_BITS - 2);
   localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] NEG_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] operand;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic                          v2_ff;
   logic [ACC_BITS-1:0]           acc_ff;
   logic signed [RND_BITS-1:0]    rnd;
   logic signed [RND_BITS-1:0]    shifted;
   logic                          fits;

   always_comb begin
      if (ctl.use_sample) begin
         operand = x0;
      end else if (ctl.hist_ok) begin
         operand = hist;
      end else begin
         operand = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= ctl.valid;
      end
      prod_ff <= coef * operand;
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + {{(ACC_BITS-PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};
      end
   end

   always_comb begin
      rnd     = $signed({acc_ff[ACC_BITS-1], acc_ff} + HALF);
      shifted = rnd >>> (SAMPLE_BITS - 1);
      fits    = (&shifted[RND_BITS-1:SAMPLE_BITS-1]) | ~(|shifted[RND_BITS-1:SAMPLE_BITS-1]);
      result_sat = ~fits;
      if (fits) begin
         result = shifted[SAMPLE_BITS-1:0];
      end else if (shifted[RND_BITS-1]) begin
         result = NEG_MIN;
      end else begin
         result = POS_MAX;
      end
   end

   assign busy = v2_ff;

endmodule

### rtl/core/fir_filter_streaming_unit.sv
// Streaming direct-form FIR filter top level: coefficient and history
// memories, tap sequencer and result register. Depends on fir_pkg, fir_mac.
//
// Usage:
//   req_* carries one item: load coefficient (tap_index, coefficient),
//   filter sample (sample) or clear history. Only a sample item gives a
//   result, on rsp_* (filtered_sample, saturated).
//   csr_* writes tap_count, the number of taps in use; write it only while
//   the block is idle. Zero counts as one tap, values above MAX_TAPS clip.
//   Load and clear items leave the block idle, ready for the next item.
//   A sample item walks one tap per cycle through the shared MAC, reading
//   one coefficient and one history entry per cycle from the memories,
//   so its result is registered after the walk and the MAC drain, and
//   the next item is accepted once the block is back in idle.
//   A finished result waits in the output register; load and clear items
//   are still accepted, and a second sample walks its taps but holds its
//   result, and the input, until rsp_ready.
//   Reset zeroes the history (by a fill count, no clearing pass), sets
//   tap_count to 51 and drops any pending result. Coefficients are
//   undefined until loaded.
module fir_filter_streaming_unit #(
   parameter int MAX_TAPS    = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic [$clog2(MAX_TAPS)-1:0]   req_tap_index,
   input  logic signed [SAMPLE_BITS-1:0] req_coefficient,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered_sample,
   output logic                          rsp_saturated,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [$clog2(MAX_TAPS+1)-1:0] csr_tap_count
);

   localparam int CIDX_W     = $clog2(MAX_TAPS);
   localparam int TC_W       = $clog2(MAX_TAPS + 1);
   localparam int HIST_DEPTH = MAX_TAPS - 1;
   localparam int HIDX_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

   fir_pkg::fir_state_type state_ff, state_in;

   logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
   logic signed [SAMPLE_BITS-1:0] coef_rd_ff;
   logic signed [SAMPLE_BITS-1:0] hist_rd_ff;

   logic [TC_W-1:0]               tap_count_ff;
   logic [TC_W-1:0]               taps_ff, taps_in;
   logic [TC_W-1:0]               k_ff, k_in;
   logic [HIDX_W-1:0]             p_ff, p_in, p_dec;
   logic [HIDX_W-1:0]             head_ff, head_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic signed [SAMPLE_BITS-1:0] x0_ff;

   logic v1_ff, v1_in;
   logic sel_x0_ff, sel_x0_in;
   logic hok_ff, hok_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic rsp_sat_ff;

   logic accept, sample_go, coef_we, clear_go;
   logic issue, last_issue, finish;
   logic mac_busy;
   logic signed [SAMPLE_BITS-1:0] mac_result;
   logic mac_sat;
   fir_pkg::mac_ctl_type mac_ctl;

   assign accept = req_valid & req_ready;

   always_comb begin
      sample_go = 1'b0;
      coef_we   = 1'b0;
      clear_go  = 1'b0;
      unique case (req_operation)
         fir_pkg::OP_LOAD:   coef_we   = accept &
            ({1'b0, req_tap_index} < (CIDX_W+1)'(MAX_TAPS));
         fir_pkg::OP_SAMPLE: sample_go = accept;
         fir_pkg::OP_CLEAR:  clear_go  = accept;
         default: ;
      endcase
   end

   assign last_issue = (k_ff == taps_ff - TC_W'(1));
   assign p_dec      = (p_ff == '0) ? HIDX_W'(HIST_DEPTH - 1) : p_ff - HIDX_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fir_pkg::ST_IDLE:   if (sample_go) state_in = fir_pkg::ST_ISSUE;
         fir_pkg::ST_ISSUE:  if (last_issue) state_in = fir_pkg::ST_DRAIN;
         fir_pkg::ST_DRAIN:  if (!v1_ff && !mac_busy) state_in = fir_pkg::ST_FINISH;
         fir_pkg::ST_FINISH: if (!rsp_valid_ff || rsp_ready) state_in = fir_pkg::ST_IDLE;
         default:            state_in = fir_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         fir_pkg::ST_IDLE:   req_ready = 1'b1;
         fir_pkg::ST_ISSUE:  issue     = 1'b1;
         fir_pkg::ST_DRAIN:  ;
         fir_pkg::ST_FINISH: finish    = !rsp_valid_ff || rsp_ready;
         default:            ;
      endcase
   end

   always_comb begin
      if (tap_count_ff == '0) begin
         taps_in = TC_W'(1);
      end else if (tap_count_ff > TC_W'(MAX_TAPS)) begin
         taps_in = TC_W'(MAX_TAPS);
      end else begin
         taps_in = tap_count_ff;
      end
      k_in      = sample_go ? '0 : (issue ? k_ff + TC_W'(1) : k_ff);
      p_in      = sample_go ? head_ff : (issue ? p_dec : p_ff);
      v1_in     = issue;
      sel_x0_in = issue && (k_ff == '0);
      hok_in    = FILL_W'(p_ff) < fill_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      if (clear_go) begin
         head_in = '0;
         fill_in = '0;
      end else if (finish) begin
         head_in = (head_ff == HIDX_W'(HIST_DEPTH - 1)) ? '0 : head_ff + HIDX_W'(1);
         fill_in = (fill_ff == FILL_W'(HIST_DEPTH)) ? fill_ff : fill_ff + FILL_W'(1);
      end
      rsp_valid_in = finish | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fir_pkg::ST_IDLE;
         tap_count_ff <= TC_W'(fir_pkg::TAP_COUNT_RESET);
         k_ff         <= '0;
         p_ff         <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         v1_ff        <= 1'b0;
         sel_x0_ff    <= 1'b0;
         hok_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid) begin
            tap_count_ff <= csr_tap_count;
         end
         k_ff         <= k_in;
         p_ff         <= p_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         v1_ff        <= v1_in;
         sel_x0_ff    <= sel_x0_in;
         hok_ff       <= hok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_go) begin
         x0_ff   <= req_sample;
         taps_ff <= taps_in;
      end
      if (finish) begin
         rsp_sample_ff <= mac_result;
         rsp_sat_ff    <= mac_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[req_tap_index] <= req_coefficient;
      end
      coef_rd_ff <= coef_mem[k_ff[CIDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         hist_mem[head_ff] <= x0_ff;
      end
      hist_rd_ff <= hist_mem[p_ff];
   end

   always_comb begin
      mac_ctl.clear      = sample_go;
      mac_ctl.valid      = v1_ff;
      mac_ctl.use_sample = sel_x0_ff;
      mac_ctl.hist_ok    = hok_ff;
   end

   fir_mac #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mac_ctl),
      .coef       (coef_rd_ff),
      .hist       (hist_rd_ff),
      .x0         (x0_ff),
      .busy       (mac_busy),
      .result     (mac_result),
      .result_sat (mac_sat)
   );

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;
   assign rsp_saturated       = rsp_sat_ff;

endmodule

### rtl/core/fir_filter_streaming_checker.sv
// Port-level assertions for the streaming FIR filter and the bind that
// attaches them to the top level. Depends on fir_pkg.
module fir_filter_streaming_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [1:0]             req_operation,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_filtered_sample,
   input logic                   rsp_saturated
);

   localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] NEG_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered_sample)
         && $stable(rsp_saturated))
      else $error("result item changed while stalled");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_filtered_sample == POS_MAX) || (rsp_filtered_sample == NEG_MIN))
      else $error("saturated result not at a bound");

   a_reset_drop: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation != fir_pkg::OP_SAMPLE) && !rsp_valid
         |=> !rsp_valid)
      else $error("result produced by a non-sample item");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == fir_pkg::OP_SAMPLE) |=> !req_ready)
      else $error("item accepted during tap walk");

endmodule

bind fir_filter_streaming_unit fir_filter_streaming_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_checker (.*);
